// ===== src/otb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
package otb_pkg;

	localparam int SLOT_FIELD_RANGE = 8;
	localparam int SLOT_W           = 3;
	localparam int OP_W             = 3;
	localparam int STATUS_W         = 2;
	localparam int TICK_W           = 32;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE  = 3'd0,
		OP_START   = 3'd1,
		OP_RESET   = 3'd2,
		OP_STOP    = 3'd3,
		OP_QUERY   = 3'd4,
		OP_PROCESS = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_NOT_CREATED = 2'd2,
		ST_NOT_ARMED   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic flush;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
	} ctl_sts_t;

endpackage

// ===== src/otb_ctrl.sv =====
// Controller state machine of the one-shot timer bank.
module otb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [otb_pkg::OP_W-1:0] operation,
	input  otb_pkg::ctl_sts_t      sts,
	output otb_pkg::ctl_cmd_t      cmd,
	output logic                   busy
);
	import otb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (op_t'(operation)) inside
						OP_CREATE, OP_START, OP_RESET, OP_STOP, OP_QUERY: state_d = S_EXEC;
						OP_PROCESS: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/otb_datapath.sv =====
// Slot table, expiry compare and result registers of the one-shot timer bank.
module otb_datapath #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  otb_pkg::ctl_cmd_t             cmd,
	output otb_pkg::ctl_sts_t             sts,
	input  logic [otb_pkg::OP_W-1:0]      operation,
	input  logic [otb_pkg::SLOT_W-1:0]    slot,
	input  logic [otb_pkg::TICK_W-1:0]    timeout,
	input  logic [otb_pkg::TICK_W-1:0]    now,
	output logic                          result_valid,
	output logic [otb_pkg::SLOT_W-1:0]    result_slot,
	output logic [otb_pkg::STATUS_W-1:0]  status,
	output logic                          armed,
	output logic                          expired,
	output logic                          last
);
	import otb_pkg::*;

	localparam int USABLE = (NUM_SLOTS < SLOT_FIELD_RANGE) ? NUM_SLOTS : SLOT_FIELD_RANGE;
	localparam int IDX_W  = (USABLE > 1) ? $clog2(USABLE) : 1;

	// Captured transaction.
	logic [OP_W-1:0]   op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TICK_W-1:0] tmo_q;
	logic [TICK_W-1:0] now_q;

	// Slot table.
	logic [USABLE-1:0] used_q;
	logic [USABLE-1:0] armed_q;
	logic [TICK_W-1:0] start_tick_q [USABLE];
	logic [TICK_W-1:0] timeout_q    [USABLE];

	// Scan position and the expiry held back until the next one is known.
	logic [IDX_W-1:0]  idx_q;
	logic              pend_vld_q;
	logic [IDX_W-1:0]  pend_slot_q;

	// Result registers.
	logic                result_valid_q;
	logic [SLOT_W-1:0]   result_slot_q;
	logic [STATUS_W-1:0] status_q;
	logic                armed_flag_q;
	logic                expired_q;
	logic                last_q;

	// Next-state and result decode.
	logic [USABLE-1:0]   used_d;
	logic [USABLE-1:0]   armed_d;
	logic                emit;
	logic [SLOT_W-1:0]   r_slot;
	status_t             r_status;
	logic                r_armed;
	logic                r_expired;
	logic                r_last;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [TICK_W-1:0]   wr_start;
	logic [TICK_W-1:0]   wr_tmo;
	logic                wr_tmo_en;

	logic [IDX_W-1:0]    sidx;
	logic                in_rng;
	logic                slot_ok;
	logic [IDX_W-1:0]    free_idx;
	logic                full;
	logic [TICK_W-1:0]   elapsed;
	logic                hit;

	assign sidx    = slot_q[IDX_W-1:0];
	assign in_rng  = ({1'b0, slot_q} < 4'(USABLE));
	assign slot_ok = in_rng && used_q[sidx];
	assign full    = &used_q;

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = USABLE - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign elapsed      = now_q - start_tick_q[idx_q];
	assign hit          = used_q[idx_q] && armed_q[idx_q] && (elapsed >= timeout_q[idx_q]);
	assign sts.scan_end = (idx_q == IDX_W'(USABLE - 1));

	always_comb begin
		used_d    = used_q;
		armed_d   = armed_q;
		emit      = 1'b0;
		r_slot    = slot_q;
		r_status  = ST_OK;
		r_armed   = 1'b0;
		r_expired = 1'b0;
		r_last    = 1'b1;
		wr_en     = 1'b0;
		wr_tmo_en = 1'b0;
		wr_idx    = sidx;
		wr_start  = now_q;
		wr_tmo    = tmo_q;

		if (cmd.exec) begin
			emit = 1'b1;
			case (op_t'(op_q))
				OP_CREATE: begin
					if (full) begin
						r_slot   = '0;
						r_status = ST_FULL;
					end else begin
						r_slot            = SLOT_W'(free_idx);
						used_d[free_idx]  = 1'b1;
						armed_d[free_idx] = 1'b0;
						wr_en             = 1'b1;
						wr_tmo_en         = 1'b1;
						wr_idx            = free_idx;
						wr_start          = '0;
						wr_tmo            = '0;
					end
				end
				OP_START: begin
					if (!slot_ok) begin
						r_status = ST_NOT_CREATED;
					end else begin
						armed_d[sidx] = 1'b1;
						wr_en         = 1'b1;
						wr_tmo_en     = 1'b1;
						r_armed       = 1'b1;
					end
				end
				OP_RESET: begin
					if (!slot_ok) begin
						r_status = ST_NOT_CREATED;
					end else if (!armed_q[sidx]) begin
						r_status = ST_NOT_ARMED;
					end else begin
						wr_en   = 1'b1;
						r_armed = 1'b1;
					end
				end
				OP_STOP: begin
					if (!slot_ok) begin
						r_status = ST_NOT_CREATED;
					end else begin
						armed_d[sidx] = 1'b0;
					end
				end
				OP_QUERY: begin
					if (!slot_ok) begin
						r_status = ST_NOT_CREATED;
					end else begin
						r_armed = armed_q[sidx];
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end

		// An expiry is only reported once the next one (or the end of the scan)
		// shows whether it is the final result of the transaction.
		if (cmd.scan && hit) begin
			armed_d[idx_q] = 1'b0;
			if (pend_vld_q) begin
				emit      = 1'b1;
				r_slot    = SLOT_W'(pend_slot_q);
				r_expired = 1'b1;
				r_last    = 1'b0;
			end
		end

		if (cmd.flush) begin
			emit = 1'b1;
			if (pend_vld_q) begin
				r_slot    = SLOT_W'(pend_slot_q);
				r_expired = 1'b1;
			end else begin
				r_slot = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q         <= '0;
			armed_q        <= '0;
			idx_q          <= '0;
			pend_vld_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			used_q         <= used_d;
			armed_q        <= armed_d;
			result_valid_q <= emit;
			if (cmd.load || cmd.flush) begin
				idx_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				if (hit) begin
					pend_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			slot_q <= slot;
			tmo_q  <= timeout;
			now_q  <= now;
		end
		if (cmd.scan && hit) begin
			pend_slot_q <= idx_q;
		end
		if (emit) begin
			result_slot_q <= r_slot;
			status_q      <= r_status;
			armed_flag_q  <= r_armed;
			expired_q     <= r_expired;
			last_q        <= r_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_tick_q[wr_idx] <= wr_start;
		end
		if (wr_tmo_en) begin
			timeout_q[wr_idx] <= wr_tmo;
		end
	end

	assign result_valid = result_valid_q;
	assign result_slot  = result_slot_q;
	assign status       = status_q;
	assign armed        = armed_flag_q;
	assign expired      = expired_q;
	assign last         = last_q;

endmodule

// ===== src/one_shot_timer_bank.sv =====
// Top level of the one-shot timer bank: controller plus datapath.
// A command is taken when start is high and busy is low. Create, start, reset, stop and
// query give one result, which is registered in the execute state, and the bank is ready
// again once that state is left. Process walks the min(NUM_SLOTS, 8) slots of the table one
// slot per clock, keeping busy high through the walk and a final flush state, and delivers
// its results during the walk, each expiry reported once the next expiry or the end of the
// walk is found, ending with last set.
// Results appear for a single cycle with result_valid high; the receiver cannot stall them.
// Operation codes 6 and 7 are dropped without a result.
module one_shot_timer_bank #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [otb_pkg::OP_W-1:0]      operation,
	input  logic [otb_pkg::SLOT_W-1:0]    slot,
	input  logic [otb_pkg::TICK_W-1:0]    timeout,
	input  logic [otb_pkg::TICK_W-1:0]    now,
	output logic                          result_valid,
	output logic [otb_pkg::SLOT_W-1:0]    result_slot,
	output logic [otb_pkg::STATUS_W-1:0]  status,
	output logic                          armed,
	output logic                          expired,
	output logic                          last
);
	import otb_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	otb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	otb_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.slot         (slot),
		.timeout      (timeout),
		.now          (now),
		.result_valid (result_valid),
		.result_slot  (result_slot),
		.status       (status),
		.armed        (armed),
		.expired      (expired),
		.last         (last)
	);

endmodule
